>>> rtl/mnd_pkg.sv
// Shared types for the maximum-number block.
// Holds the sequencer state encoding and the digit width; no dependencies.
`timescale 1ns / 1ps

package mnd_pkg;

  localparam int DigitW = 4;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_K_START = 15'b000000000000010,
    ST_K_RD    = 15'b000000000000100,
    ST_K_CHK   = 15'b000000000001000,
    ST_K_POP   = 15'b000000000010000,
    ST_M_RD    = 15'b000000000100000,
    ST_M_CMP   = 15'b000000001000000,
    ST_M_TAKE  = 15'b000000010000000,
    ST_M_WR    = 15'b000000100000000,
    ST_C_RD    = 15'b000001000000000,
    ST_C_CMP   = 15'b000010000000000,
    ST_Y_RD    = 15'b000100000000000,
    ST_Y_WR    = 15'b001000000000000,
    ST_E_RD    = 15'b010000000000000,
    ST_E_VAL   = 15'b100000000000000
  } mnd_state_e;

endpackage

>>> rtl/max_number_from_two_digit_lists_core.sv
// Maximum number from two digit lists: top level with the sequencer.
// Load: one request per cycle while idle (in_ready_o high). After the request marked last,
// the search runs, paced by the single read port of each RAM in the merge compare.
// Each result digit is first read from the RAM, then presented.
// Reset (rst_ni low, asynchronous) clears counts, the sequencer and sets the configured k to 1.
// Uses mnd_pkg and mnd_ram.
`timescale 1ns / 1ps

module max_number_from_two_digit_lists_core #(
  parameter int MAX_LEN = 32,
  parameter int MAX_K   = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [6:0]                 cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [mnd_pkg::DigitW-1:0] digit_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mnd_pkg::DigitW-1:0] out_digit_o,
  output logic                       out_last_o,
  output logic                       too_long_o
);

  import mnd_pkg::*;

  // Index widths for the list/pick RAMs and the candidate/best RAMs.
  localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int KW = $clog2(MAX_K);
  localparam int CW = $clog2(MAX_LEN + 1);
  // Working width for every length, index and offset of the search.
  localparam int VW = $clog2(MAX_K + 2 * MAX_LEN + 1);

  mnd_state_e state_q, state_d;

  logic [6:0]        rl_q;
  logic [CW-1:0]     m_q, m_d, n_q, n_d;
  logic [VW-1:0]     mlen_q, mlen_d, nlen_q, nlen_d, k_q, k_d;
  logic [VW-1:0]     i_q, i_d, hi_q, hi_d;
  logic [VW-1:0]     p_q, p_d, top_q, top_d, bud_q, bud_d;
  logic [VW-1:0]     mi_q, mi_d, mj_q, mj_d, mo_q, mo_d, x_q, x_d;
  logic [DigitW-1:0] tos_q, tos_d;
  logic              side_q, side_d, gt_q, gt_d, have_q, have_d, err_q, err_d;

  // RAM ports.
  logic              l1_we, l2_we, l1_re, l2_re;
  logic [LW-1:0]     l1_waddr, l2_waddr, list_raddr;
  logic [DigitW-1:0] l1_rd, l2_rd;
  logic              p1_we, p2_we, p1_re, p2_re;
  logic [LW-1:0]     pick_waddr, p1_raddr, p2_raddr;
  logic [DigitW-1:0] pick_wdata, p1_rd, p2_rd;
  logic              c_we, c_re, b_we, b_re;
  logic [KW-1:0]     c_waddr, c_raddr, b_waddr, b_raddr;
  logic [DigitW-1:0] c_wdata, c_rd, b_rd;

  // Derived values for the current split and the active list.
  logic [VW-1:0]     m_inc, n_inc, k_sat, klen, kwant, la, lb, ia, jb, topm2;
  logic [DigitW-1:0] kd;
  logic              keep_end, split_end;

  assign m_inc = VW'(m_q) + VW'(in_valid_i && !func_i && (m_q < CW'(MAX_LEN)));
  assign n_inc = VW'(n_q) + VW'(in_valid_i && func_i && (n_q < CW'(MAX_LEN)));
  assign k_sat = (rl_q > 7'(MAX_K)) ? VW'(MAX_K) : VW'(rl_q);
  assign la    = i_q;
  assign lb    = k_q - i_q;
  assign klen  = side_q ? nlen_q : mlen_q;
  assign kwant = side_q ? lb : la;
  assign kd    = side_q ? l2_rd : l1_rd;
  assign ia    = mi_q + x_q;
  assign jb    = mj_q + x_q;
  assign topm2 = top_q - VW'(2);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_E_VAL);
  assign out_digit_o = err_q ? '0 : b_rd;
  assign too_long_o  = err_q;
  assign out_last_o  = err_q || (x_q + VW'(1) == k_q);

  // Loading writes straight into the list RAMs; a full list drops the digit.
  assign l1_we      = in_valid_i && in_ready_o && !func_i && (m_q < CW'(MAX_LEN));
  assign l2_we      = in_valid_i && in_ready_o && func_i && (n_q < CW'(MAX_LEN));
  assign l1_waddr   = m_q[LW-1:0];
  assign l2_waddr   = n_q[LW-1:0];
  assign list_raddr = p_q[LW-1:0];

  always_comb begin
    state_d = state_q;
    m_d = m_q;       n_d = n_q;       mlen_d = mlen_q; nlen_d = nlen_q;
    k_d = k_q;       i_d = i_q;       hi_d = hi_q;
    p_d = p_q;       top_d = top_q;   bud_d = bud_q;   tos_d = tos_q;
    mi_d = mi_q;     mj_d = mj_q;     mo_d = mo_q;     x_d = x_q;
    side_d = side_q; gt_d = gt_q;     have_d = have_q; err_d = err_q;
    keep_end = 1'b0; split_end = 1'b0;
    l1_re = 1'b0; l2_re = 1'b0;
    p1_we = 1'b0; p2_we = 1'b0; p1_re = 1'b0; p2_re = 1'b0;
    pick_waddr = top_q[LW-1:0];
    pick_wdata = kd;
    p1_raddr = topm2[LW-1:0];
    p2_raddr = topm2[LW-1:0];
    c_we = 1'b0; c_re = 1'b0; b_we = 1'b0; b_re = 1'b0;
    c_waddr = mo_q[KW-1:0];
    c_wdata = gt_q ? p1_rd : p2_rd;
    c_raddr = x_q[KW-1:0];
    b_waddr = x_q[KW-1:0];
    b_raddr = x_q[KW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          m_d = m_inc[CW-1:0];
          n_d = n_inc[CW-1:0];
          if (last_i) begin
            m_d = '0;
            n_d = '0;
            mlen_d = m_inc;
            nlen_d = n_inc;
            k_d = k_sat;
            x_d = '0;
            have_d = 1'b0;
            if (k_sat == '0) begin
              state_d = ST_IDLE;
            end else if (k_sat > m_inc + n_inc) begin
              err_d = 1'b1;
              state_d = ST_E_VAL;
            end else begin
              err_d = 1'b0;
              i_d = (k_sat > n_inc) ? k_sat - n_inc : '0;
              hi_d = (k_sat < m_inc) ? k_sat : m_inc;
              side_d = 1'b0;
              state_d = ST_K_START;
            end
          end
        end
      end
      ST_K_START: begin
        p_d = '0;
        top_d = '0;
        bud_d = klen - kwant;
        if (klen == '0) begin
          keep_end = 1'b1;
        end else begin
          state_d = ST_K_RD;
        end
      end
      ST_K_RD: begin
        l1_re = !side_q;
        l2_re = side_q;
        state_d = ST_K_CHK;
      end
      ST_K_CHK: begin
        if (bud_q != '0 && top_q != '0 && tos_q < kd) begin
          // Pop: the new top of stack has to come back from the pick RAM.
          top_d = top_q - VW'(1);
          bud_d = bud_q - VW'(1);
          if (top_q > VW'(1)) begin
            p1_re = !side_q;
            p2_re = side_q;
            state_d = ST_K_POP;
          end
        end else begin
          p1_we = !side_q;
          p2_we = side_q;
          tos_d = kd;
          top_d = top_q + VW'(1);
          p_d = p_q + VW'(1);
          if (p_q + VW'(1) == klen) begin
            keep_end = 1'b1;
          end else begin
            state_d = ST_K_RD;
          end
        end
      end
      ST_K_POP: begin
        tos_d = side_q ? p2_rd : p1_rd;
        state_d = ST_K_CHK;
      end
      ST_M_RD: begin
        if (ia < la && jb < lb) begin
          p1_re = 1'b1;
          p1_raddr = ia[LW-1:0];
          p2_re = 1'b1;
          p2_raddr = jb[LW-1:0];
          state_d = ST_M_CMP;
        end else begin
          gt_d = (la - ia) > (lb - jb);
          state_d = ST_M_TAKE;
        end
      end
      ST_M_CMP: begin
        if (p1_rd != p2_rd) begin
          gt_d = p1_rd > p2_rd;
          state_d = ST_M_TAKE;
        end else begin
          x_d = x_q + VW'(1);
          state_d = ST_M_RD;
        end
      end
      ST_M_TAKE: begin
        p1_re = gt_q;
        p1_raddr = mi_q[LW-1:0];
        p2_re = !gt_q;
        p2_raddr = mj_q[LW-1:0];
        state_d = ST_M_WR;
      end
      ST_M_WR: begin
        c_we = 1'b1;
        if (gt_q) begin
          mi_d = mi_q + VW'(1);
        end else begin
          mj_d = mj_q + VW'(1);
        end
        mo_d = mo_q + VW'(1);
        x_d = '0;
        if (mo_q + VW'(1) == k_q) begin
          state_d = have_q ? ST_C_RD : ST_Y_RD;
        end else begin
          state_d = ST_M_RD;
        end
      end
      ST_C_RD: begin
        if (x_q < k_q) begin
          c_re = 1'b1;
          b_re = 1'b1;
          state_d = ST_C_CMP;
        end else begin
          split_end = 1'b1;
        end
      end
      ST_C_CMP: begin
        if (c_rd != b_rd) begin
          if (c_rd > b_rd) begin
            x_d = '0;
            state_d = ST_Y_RD;
          end else begin
            split_end = 1'b1;
          end
        end else begin
          x_d = x_q + VW'(1);
          state_d = ST_C_RD;
        end
      end
      ST_Y_RD: begin
        c_re = 1'b1;
        state_d = ST_Y_WR;
      end
      ST_Y_WR: begin
        b_we = 1'b1;
        have_d = 1'b1;
        x_d = x_q + VW'(1);
        if (x_q + VW'(1) == k_q) begin
          split_end = 1'b1;
        end else begin
          state_d = ST_Y_RD;
        end
      end
      ST_E_RD: begin
        b_re = 1'b1;
        state_d = ST_E_VAL;
      end
      ST_E_VAL: begin
        if (out_ready_i) begin
          if (err_q || x_q + VW'(1) == k_q) begin
            state_d = ST_IDLE;
          end else begin
            x_d = x_q + VW'(1);
            state_d = ST_E_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // After the first list's stack is built, the second follows; then merge.
    if (keep_end) begin
      if (!side_q) begin
        side_d = 1'b1;
        state_d = ST_K_START;
      end else begin
        mi_d = '0;
        mj_d = '0;
        mo_d = '0;
        x_d = '0;
        state_d = ST_M_RD;
      end
    end

    // Move to the next split of k, or start emitting the best candidate.
    if (split_end) begin
      x_d = '0;
      if (i_q == hi_q) begin
        state_d = ST_E_RD;
      end else begin
        i_d = i_q + VW'(1);
        side_d = 1'b0;
        state_d = ST_K_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rl_q <= 7'd1;
      m_q <= '0;
      n_q <= '0;
      err_q <= 1'b0;
      x_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rl_q <= cfg_wdata_i;
      end
      m_q <= m_d;
      n_q <= n_d;
      err_q <= err_d;
      x_q <= x_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mlen_q <= mlen_d; nlen_q <= nlen_d;
    i_q <= i_d;       hi_q <= hi_d;
    p_q <= p_d;       top_q <= top_d;   bud_q <= bud_d;   tos_q <= tos_d;
    mi_q <= mi_d;     mj_q <= mj_d;     mo_q <= mo_d;
    side_q <= side_d; gt_q <= gt_d;     have_q <= have_d;
  end

  mnd_ram #(.Depth(MAX_LEN), .Width(DigitW)) u_list1 (
    .clk_i, .we_i(l1_we), .waddr_i(l1_waddr), .wdata_i(digit_i),
    .re_i(l1_re), .raddr_i(list_raddr), .rdata_o(l1_rd)
  );

  mnd_ram #(.Depth(MAX_LEN), .Width(DigitW)) u_list2 (
    .clk_i, .we_i(l2_we), .waddr_i(l2_waddr), .wdata_i(digit_i),
    .re_i(l2_re), .raddr_i(list_raddr), .rdata_o(l2_rd)
  );

  mnd_ram #(.Depth(MAX_LEN), .Width(DigitW)) u_pick1 (
    .clk_i, .we_i(p1_we), .waddr_i(pick_waddr), .wdata_i(pick_wdata),
    .re_i(p1_re), .raddr_i(p1_raddr), .rdata_o(p1_rd)
  );

  mnd_ram #(.Depth(MAX_LEN), .Width(DigitW)) u_pick2 (
    .clk_i, .we_i(p2_we), .waddr_i(pick_waddr), .wdata_i(pick_wdata),
    .re_i(p2_re), .raddr_i(p2_raddr), .rdata_o(p2_rd)
  );

  mnd_ram #(.Depth(MAX_K), .Width(DigitW)) u_cand (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .re_i(c_re), .raddr_i(c_raddr), .rdata_o(c_rd)
  );

  mnd_ram #(.Depth(MAX_K), .Width(DigitW)) u_best (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(c_rd),
    .re_i(b_re), .raddr_i(b_raddr), .rdata_o(b_rd)
  );

  // Results are never offered while new requests are taken.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("result offered while accepting requests");

  // The stack can never hold more digits than have been read.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_K_CHK) |-> (top_q <= p_q))
    else $error("stack deeper than digits consumed");

  // Merge writes stay within the k candidate positions.
  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M_WR) |-> (mo_q < k_q))
    else $error("merge wrote past k digits");

  // An error result is always the only and final one.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_long_o) |-> (out_last_o && out_digit_o == '0))
    else $error("error result not marked last");

endmodule

>>> rtl/mnd_ram.sv
// Simple dual-port synchronous RAM with a registered, read-enabled output.
// Generic storage used by the maximum-number core; no dependencies.
`timescale 1ns / 1ps

module mnd_ram #(
  parameter int Depth = 32,
  parameter int Width = 4
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
